### rtl/stok_pkg.sv
`timescale 1ns / 1ps

package stok_pkg;

	typedef enum logic [3:0] {
		M_IDLE     = 4'd0,
		M_SLASH    = 4'd1,
		M_OP       = 4'd2,
		M_COMMENT  = 4'd3,
		M_STRING   = 4'd4,
		M_NUMBER   = 4'd5,
		M_NUMDOT   = 4'd6,
		M_FRACTION = 4'd7,
		M_IDENT    = 4'd8
	} mode_t;

	localparam logic [4:0] K_SLASH    = 5'd10;
	localparam logic [4:0] K_BANG     = 5'd11;
	localparam logic [4:0] K_ASSIGN   = 5'd13;
	localparam logic [4:0] K_LESS     = 5'd15;
	localparam logic [4:0] K_GREATER  = 5'd17;
	localparam logic [4:0] K_STRING   = 5'd19;
	localparam logic [4:0] K_NUMBER   = 5'd20;
	localparam logic [4:0] K_IDENT    = 5'd21;
	localparam logic [4:0] K_KEYWORD0 = 5'd22;
	localparam logic [4:0] K_EOF      = 5'd31;
	localparam logic [4:0] K_NONE     = 5'd0;

	localparam logic [1:0] E_NONE       = 2'd0;
	localparam logic [1:0] E_UNEXPECTED = 2'd1;
	localparam logic [1:0] E_UNTERM     = 2'd2;

	localparam int NUM_KEYWORDS = 9;
	localparam int NUM_SINGLES  = 10;
	localparam logic [3:0] NO_SINGLE = 4'd15;

	// keywords packed first byte lowest
	localparam logic [55:0] KEYWORDS [NUM_KEYWORDS] = '{
		56'h6669,          // if
		56'h65736c65,      // else
		56'h656c696877,    // while
		56'h74616f6c66,    // float
		56'h746e69,        // int
		56'h64696f76,      // void
		56'h72616863,      // char
		56'h746e697270,    // print
		56'h6e7275746572   // return
	};

	localparam logic [7:0] SINGLES [NUM_SINGLES] = '{
		8'h2c, 8'h3b, 8'h28, 8'h29, 8'h7b, 8'h7d, 8'h2b, 8'h2d, 8'h2a, 8'h25
	};

	typedef struct packed {
		logic [4:0]  kind;
		logic [1:0]  err;
		logic [15:0] start;
		logic [15:0] len;
		logic [15:0] line;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} close_t;

	function automatic logic [4:0] word_kind(input logic [55:0] prefix);
		logic [4:0] k;
		k = K_IDENT;
		for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
			if (prefix == KEYWORDS[i]) k = K_KEYWORD0 + 5'(i);
		end
		return k;
	endfunction

	function automatic logic [3:0] single_index(input logic [7:0] c);
		logic [3:0] idx;
		idx = NO_SINGLE;
		for (int i = NUM_SINGLES - 1; i >= 0; i--) begin
			if (c == SINGLES[i]) idx = 4'(i);
		end
		return idx;
	endfunction

	function automatic logic [4:0] op_kind(input logic [7:0] c, input logic with_eq);
		logic [4:0] base;
		if (c == 8'h21) base = K_BANG;
		else if (c == 8'h3d) base = K_ASSIGN;
		else if (c == 8'h3c) base = K_LESS;
		else base = K_GREATER;
		return base + {4'd0, with_eq};
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) || c == 8'h5f;
	endfunction

	function automatic logic [55:0] prefix_push(input logic [55:0] p, input logic [7:0] c);
		logic [55:0] r;
		logic        done;
		r = p;
		done = 1'b0;
		for (int i = 0; i < 7; i++) begin
			if (!done && p[8*i +: 8] == 8'd0) begin
				r[8*i +: 8] = c;
				done = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

### rtl/source_tokenizer.sv
`timescale 1ns / 1ps

// Streaming lexer: one source byte per item, accepted every cycle unless
// stalled. Each item is registered, scanned combinationally, and its zero to
// four results go into an eight-entry result queue that drains one result
// per cycle while out_stall is low; an item waits in the input register
// while fewer than four queue entries are free. Results of one item leave in
// order, the last one flagged by last_result; the end of the source flushes
// any pending token, emits EOF and returns the scanner to reset.
module source_tokenizer #(
	parameter int OFFSET_BITS = 16,
	parameter int LINE_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_byte,
	input  logic        has_char,
	input  logic        end_of_source,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  token_kind,
	output logic [1:0]  error_kind,
	output logic [15:0] start_offset,
	output logic [15:0] lexeme_length,
	output logic [15:0] line_number,
	output logic        last_result
);

	localparam int QDEPTH = 8;
	localparam int QBITS  = $clog2(QDEPTH);
	localparam logic [OFFSET_BITS-1:0] POS_MAX  = {OFFSET_BITS{1'b1}};
	localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};

	// input register
	logic        v_s1;
	logic [7:0]  char_s1;
	logic        has_s1;
	logic        eos_s1;

	// scanner state
	stok_pkg::mode_t        mode_q;
	logic [7:0]             pchar_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] tstart_q;
	logic [LINE_BITS-1:0]   line_q;
	logic [55:0]            prefix_q;

	stok_pkg::mode_t        mode_d;
	logic [7:0]             pchar_d;
	logic [OFFSET_BITS-1:0] pos_d;
	logic [OFFSET_BITS-1:0] tstart_d;
	logic [LINE_BITS-1:0]   line_d;
	logic [55:0]            prefix_d;

	stok_pkg::result_t res [4];
	logic [2:0]        nres;

	stok_pkg::result_t      queue_q [QDEPTH];
	logic [QBITS-1:0]       wr_q;
	logic [QBITS-1:0]       rd_q;
	logic [QBITS:0]         cnt_q;

	logic room;
	logic fire;
	logic pop;
	logic accept;

	function automatic logic [15:0] clip(input logic [32:0] v);
		return (v > 33'd65535) ? 16'hffff : v[15:0];
	endfunction

	function automatic stok_pkg::result_t mk(
		input logic [4:0]             kind,
		input logic [1:0]             err,
		input logic [OFFSET_BITS:0]   s,
		input logic [OFFSET_BITS:0]   e,
		input logic [LINE_BITS-1:0]   line
	);
		stok_pkg::result_t r;
		r.kind  = kind;
		r.err   = err;
		r.start = clip(33'(s));
		r.len   = (e > s) ? clip(33'(e - s)) : 16'd0;
		r.line  = clip(33'(line));
		r.last  = 1'b0;
		return r;
	endfunction

	function automatic stok_pkg::close_t close_f(
		input stok_pkg::mode_t        m,
		input logic [7:0]             pc,
		input logic [OFFSET_BITS-1:0] ts,
		input logic [OFFSET_BITS:0]   e,
		input logic [55:0]            pf,
		input logic [LINE_BITS-1:0]   line
	);
		stok_pkg::close_t       cl;
		logic [OFFSET_BITS:0]   s;
		logic [OFFSET_BITS:0]   dot;
		cl = '0;
		s = {1'b0, ts};
		dot = (e != '0) ? e - 1'b1 : '0;
		case (m)
			stok_pkg::M_SLASH: begin
				cl.n = 2'd1;
				cl.r0 = mk(stok_pkg::K_SLASH, stok_pkg::E_NONE, s, e, line);
			end
			stok_pkg::M_OP: begin
				cl.n = 2'd1;
				cl.r0 = mk(stok_pkg::op_kind(pc, 1'b0), stok_pkg::E_NONE, s, e, line);
			end
			stok_pkg::M_STRING: begin
				cl.n = 2'd1;
				cl.r0 = mk(stok_pkg::K_NONE, stok_pkg::E_UNTERM, s, e, line);
			end
			stok_pkg::M_NUMBER, stok_pkg::M_FRACTION: begin
				cl.n = 2'd1;
				cl.r0 = mk(stok_pkg::K_NUMBER, stok_pkg::E_NONE, s, e, line);
			end
			stok_pkg::M_NUMDOT: begin
				// number ends before a dot with no digit after it
				cl.n = 2'd2;
				cl.r0 = mk(stok_pkg::K_NUMBER, stok_pkg::E_NONE, s, dot, line);
				cl.r1 = mk(stok_pkg::K_NONE, stok_pkg::E_UNEXPECTED, dot, dot + 1'b1, line);
			end
			stok_pkg::M_IDENT: begin
				cl.n = 2'd1;
				cl.r0 = mk(stok_pkg::word_kind(pf), stok_pkg::E_NONE, s, e, line);
			end
			default: cl.n = 2'd0;
		endcase
		return cl;
	endfunction

	assign room     = (cnt_q <= (QBITS+1)'(QDEPTH - 4));
	assign fire     = v_s1 && room;
	assign in_stall = v_s1 && !room;
	assign accept   = in_valid && !in_stall;
	assign out_valid = (cnt_q != '0);
	assign pop      = out_valid && !out_stall;

	always_comb begin
		stok_pkg::close_t     cl;
		logic [7:0]           c;
		logic [OFFSET_BITS-1:0] here;
		logic                 used;
		logic [3:0]           si;
		mode_d   = mode_q;
		pchar_d  = pchar_q;
		pos_d    = pos_q;
		tstart_d = tstart_q;
		line_d   = line_q;
		prefix_d = prefix_q;
		nres     = 3'd0;
		c        = char_s1;
		here     = pos_q;
		used     = 1'b0;
		si       = stok_pkg::single_index(char_s1);
		cl       = '0;
		for (int i = 0; i < 4; i++) res[i] = '0;

		if (has_s1) begin
			case (mode_d)
				stok_pkg::M_SLASH: begin
					if (c == 8'h2f) begin
						mode_d = stok_pkg::M_COMMENT;
						used = 1'b1;
					end else begin
						cl = close_f(mode_d, pchar_d, tstart_d, {1'b0, here}, prefix_d, line_d);
						mode_d = stok_pkg::M_IDLE;
					end
				end
				stok_pkg::M_OP: begin
					if (c == 8'h3d) begin
						res[nres[1:0]] = mk(stok_pkg::op_kind(pchar_d, 1'b1), stok_pkg::E_NONE,
							{1'b0, tstart_d}, {1'b0, here} + 1'b1, line_d);
						nres = nres + 3'd1;
						mode_d = stok_pkg::M_IDLE;
						used = 1'b1;
					end else begin
						cl = close_f(mode_d, pchar_d, tstart_d, {1'b0, here}, prefix_d, line_d);
						mode_d = stok_pkg::M_IDLE;
					end
				end
				stok_pkg::M_COMMENT: begin
					if (c == 8'h0a) mode_d = stok_pkg::M_IDLE;
					else used = 1'b1;
				end
				stok_pkg::M_STRING: begin
					if (c == 8'h22) begin
						res[nres[1:0]] = mk(stok_pkg::K_STRING, stok_pkg::E_NONE,
							{1'b0, tstart_d}, {1'b0, here} + 1'b1, line_d);
						nres = nres + 3'd1;
						mode_d = stok_pkg::M_IDLE;
					end else if (c == 8'h0a) begin
						if (line_d != LINE_MAX) line_d = line_d + 1'b1;
					end
					used = 1'b1;
				end
				stok_pkg::M_NUMBER: begin
					if (stok_pkg::is_digit(c)) used = 1'b1;
					else if (c == 8'h2e) begin
						mode_d = stok_pkg::M_NUMDOT;
						used = 1'b1;
					end else begin
						cl = close_f(mode_d, pchar_d, tstart_d, {1'b0, here}, prefix_d, line_d);
						mode_d = stok_pkg::M_IDLE;
					end
				end
				stok_pkg::M_NUMDOT: begin
					if (stok_pkg::is_digit(c)) begin
						mode_d = stok_pkg::M_FRACTION;
						used = 1'b1;
					end else begin
						cl = close_f(mode_d, pchar_d, tstart_d, {1'b0, here}, prefix_d, line_d);
						mode_d = stok_pkg::M_IDLE;
					end
				end
				stok_pkg::M_FRACTION: begin
					if (stok_pkg::is_digit(c)) used = 1'b1;
					else begin
						cl = close_f(mode_d, pchar_d, tstart_d, {1'b0, here}, prefix_d, line_d);
						mode_d = stok_pkg::M_IDLE;
					end
				end
				stok_pkg::M_IDENT: begin
					if (stok_pkg::is_alpha(c) || stok_pkg::is_digit(c)) begin
						prefix_d = stok_pkg::prefix_push(prefix_d, c);
						used = 1'b1;
					end else begin
						cl = close_f(mode_d, pchar_d, tstart_d, {1'b0, here}, prefix_d, line_d);
						mode_d = stok_pkg::M_IDLE;
					end
				end
				default: mode_d = stok_pkg::M_IDLE;
			endcase

			if (cl.n != 2'd0) begin
				res[nres[1:0]] = cl.r0;
				nres = nres + 3'd1;
			end
			if (cl.n == 2'd2) begin
				res[nres[1:0]] = cl.r1;
				nres = nres + 3'd1;
			end

			if (!used) begin
				tstart_d = here;
				if (si != stok_pkg::NO_SINGLE) begin
					res[nres[1:0]] = mk(5'(si), stok_pkg::E_NONE, {1'b0, here},
						{1'b0, here} + 1'b1, line_d);
					nres = nres + 3'd1;
				end else if (c == 8'h2f) begin
					mode_d = stok_pkg::M_SLASH;
				end else if (c == 8'h21 || c == 8'h3d || c == 8'h3c || c == 8'h3e) begin
					mode_d = stok_pkg::M_OP;
					pchar_d = c;
				end else if (c == 8'h20 || c == 8'h09 || c == 8'h0d) begin
					mode_d = mode_d;
				end else if (c == 8'h0a) begin
					if (line_d != LINE_MAX) line_d = line_d + 1'b1;
				end else if (c == 8'h22) begin
					mode_d = stok_pkg::M_STRING;
				end else if (stok_pkg::is_digit(c)) begin
					mode_d = stok_pkg::M_NUMBER;
				end else if (stok_pkg::is_alpha(c)) begin
					mode_d = stok_pkg::M_IDENT;
					prefix_d = {48'd0, c};
				end else begin
					res[nres[1:0]] = mk(stok_pkg::K_NONE, stok_pkg::E_UNEXPECTED, {1'b0, here},
						{1'b0, here} + 1'b1, line_d);
					nres = nres + 3'd1;
				end
			end
			pos_d = (here == POS_MAX) ? here : here + 1'b1;
		end

		if (eos_s1) begin
			cl = close_f(mode_d, pchar_d, tstart_d, {1'b0, pos_d}, prefix_d, line_d);
			if (cl.n != 2'd0) begin
				res[nres[1:0]] = cl.r0;
				nres = nres + 3'd1;
			end
			if (cl.n == 2'd2) begin
				res[nres[1:0]] = cl.r1;
				nres = nres + 3'd1;
			end
			res[nres[1:0]] = mk(stok_pkg::K_EOF, stok_pkg::E_NONE, {1'b0, pos_d},
				{1'b0, pos_d}, line_d);
			nres = nres + 3'd1;
			mode_d   = stok_pkg::M_IDLE;
			pchar_d  = '0;
			pos_d    = '0;
			tstart_d = '0;
			line_d   = LINE_BITS'(1);
			prefix_d = '0;
		end

		if (nres != 3'd0) res[2'(nres - 3'd1)].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			mode_q   <= stok_pkg::M_IDLE;
			pchar_q  <= '0;
			pos_q    <= '0;
			tstart_q <= '0;
			line_q   <= LINE_BITS'(1);
			prefix_q <= '0;
			wr_q     <= '0;
			rd_q     <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) v_s1 <= 1'b1;
			else if (fire) v_s1 <= 1'b0;
			if (fire) begin
				mode_q   <= mode_d;
				pchar_q  <= pchar_d;
				pos_q    <= pos_d;
				tstart_q <= tstart_d;
				line_q   <= line_d;
				prefix_q <= prefix_d;
				wr_q     <= wr_q + QBITS'(nres);
			end
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (fire ? (QBITS+1)'(nres) : '0) - (QBITS+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_byte;
			has_s1  <= has_char;
			eos_s1  <= end_of_source;
		end
		if (fire) begin
			for (int i = 0; i < 4; i++) begin
				if (3'(i) < nres) queue_q[wr_q + QBITS'(i)] <= res[i];
			end
		end
	end

	assign token_kind    = queue_q[rd_q].kind;
	assign error_kind    = queue_q[rd_q].err;
	assign start_offset  = queue_q[rd_q].start;
	assign lexeme_length = queue_q[rd_q].len;
	assign line_number   = queue_q[rd_q].line;
	assign last_result   = queue_q[rd_q].last;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QBITS+1)'(QDEPTH))
		else $error("result queue overflow");

	a_eos_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eos_s1 |=> mode_q == stok_pkg::M_IDLE && pos_q == '0)
		else $error("scanner not reset after end of source");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && cnt_q > (QBITS+1)'(QDEPTH - 4))
		else $error("input stalled without a waiting item");

endmodule
